[hw/rtl/vtpg_pkg.sv]
// Shared constants and types for the video test pattern generator.
// No dependencies; imported by the top level and its checker.
package vtpg_pkg;

    // Field and register widths
    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 13;
    localparam int FRAME_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int PAT_W      = 2;
    localparam int REG_IDX_W  = 2;

    // Pattern constants
    localparam int GRID_LOG      = 4;   // grid pitch 16
    localparam int BAND_LOG      = 4;   // 16 gray bands
    localparam int BAND_W        = BAND_LOG;
    localparam int BAND_LAST     = 15;
    localparam int BAR_SPEED_LOG = 3;   // bar moves 8 pixels per frame
    localparam int BAR_WIDTH     = 64;

    // Pipelined remainder for the bar start position
    localparam int DVD_W          = FRAME_W + BAR_SPEED_LOG;
    localparam int STEPS_PER_STG  = 4;
    localparam int DIV_STAGES     = (DVD_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
    localparam int DVD_PAD_W      = DIV_STAGES * STEPS_PER_STG;
    localparam int NUM_STAGES     = DIV_STAGES + 2;

    // Compare widths
    localparam int MULT_W   = DIM_W + BAND_LOG;
    localparam int SCALED_W = COORD_BITS + BAND_LOG;
    localparam int CMP_W    = (MULT_W > SCALED_W) ? MULT_W : SCALED_W;
    localparam int POS_W    = (COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = '1;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = '0;

    // Register indexes on the config port
    localparam logic [REG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT  = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

    typedef enum logic [PAT_W-1:0] {
        PAT_MAGENTA = 2'd0,
        PAT_GRID    = 2'd1,
        PAT_GRAY    = 2'd2,
        PAT_BAR     = 2'd3
    } pattern_t;

    // band * 255 / 15
    localparam logic [CHAN_W-1:0] LEVEL_TABLE [16] = '{
        8'd0,   8'd17,  8'd34,  8'd51,  8'd68,  8'd85,  8'd102, 8'd119,
        8'd136, 8'd153, 8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255
    };

endpackage

[hw/rtl/video_test_pattern_generator.sv]
// Video test pattern generator top level: seven-stage pixel pipeline.
// Depends on vtpg_pkg.
//
// Takes one pixel request (column, row, frame_number) per word and returns one
// opaque BGRA pixel of the pattern in pattern_select: solid magenta, a 16-pixel
// white grid on black, sixteen gray bands across frame_width, or a 64-pixel
// white bar whose left edge is (frame_number*8) mod frame_width. Pixels outside
// frame_width x frame_height come out opaque black. Throughput is one pixel per
// clock while out_stall is low. The word passes seven register stages.
// The depth is set by the five-stage restoring remainder that places the bar
// (four bits per stage), followed by one band-compare stage and one color-select
// stage. Each stage holds its word while the next is full, so bubbles close up
// under out_stall.
// Config registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no pixel is in flight.
module video_test_pattern_generator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vtpg_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [vtpg_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [vtpg_pkg::COORD_BITS-1:0]    column,
    input  logic [vtpg_pkg::COORD_BITS-1:0]    row,
    input  logic [vtpg_pkg::FRAME_W-1:0]       frame_number,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [vtpg_pkg::CHAN_W-1:0]        blue,
    output logic [vtpg_pkg::CHAN_W-1:0]        green,
    output logic [vtpg_pkg::CHAN_W-1:0]        red,
    output logic [vtpg_pkg::CHAN_W-1:0]        alpha
);
    import vtpg_pkg::*;

    // Per-stage word; fields fill in as the pixel moves down the pipe
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic                  in_frame;
        logic                  grid;
        logic [DVD_PAD_W-1:0]  dvd;        // frame_number*8, MSB first
        logic [DIM_W-1:0]      rem;        // running remainder, bar start at the end
        logic [BAND_LAST-1:0]  band_therm; // thermometer code of the gray band
        logic                  bar_on;
        logic [CHAN_W-1:0]     blue;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     red;
    } stage_t;

    // One restoring remainder step: shift in one dividend bit, subtract if able
    function automatic logic [DIM_W-1:0] rem_step(
        input logic [DIM_W-1:0] r,
        input logic             b,
        input logic [DIM_W-1:0] w
    );
        logic [DIM_W:0] t;
        t = {r, b};
        if (t >= {1'b0, w})
        begin
            t = t - {1'b0, w};
        end
        return t[DIM_W-1:0];
    endfunction

    // Config registers
    pattern_t         pattern_reg;
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    // k*frame_width for k = 1..15, refreshed every cycle
    logic [MULT_W-1:0] mult_reg  [BAND_LAST];
    logic [MULT_W-1:0] mult_next [BAND_LAST];

    // Pipeline
    stage_t stage_reg   [NUM_STAGES];
    stage_t stage_next  [NUM_STAGES];
    logic   valid_reg   [NUM_STAGES];
    logic   stage_ready [NUM_STAGES];

    // ---------------------------------------------------------------------
    // Config writes; indexes past the list are ignored
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg      <= PAT_MAGENTA;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN: pattern_reg      <= pattern_t'(cfg_data[PAT_W-1:0]);
                REG_WIDTH:   frame_width_reg  <= cfg_data;
                REG_HEIGHT:  frame_height_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Band boundaries: constant multiples, shift-and-add only
    always_comb
    begin
        for (int k = 0; k < BAND_LAST; k++)
        begin
            mult_next[k] = MULT_W'(frame_width_reg) * MULT_W'(k + 1);
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: a stage takes a word when it is empty or its word moves on
    // ---------------------------------------------------------------------
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign in_stall = !stage_ready[0];

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    always_comb
    begin
        stage_t            s;
        logic [DIM_W-1:0]  r;
        logic [BAND_W-1:0] band;
        logic [CHAN_W-1:0] v;

        // Stage 0: frame bounds, grid hit, first remainder digits
        s            = '0;
        s.col        = column;
        s.in_frame   = (POS_W'(column) < POS_W'(frame_width_reg)) &&
                       (POS_W'(row) < POS_W'(frame_height_reg));
        s.grid       = (column[GRID_LOG-1:0] == '0) || (row[GRID_LOG-1:0] == '0);
        s.dvd        = DVD_PAD_W'({frame_number, {BAR_SPEED_LOG{1'b0}}});
        r            = '0;
        for (int j = 0; j < STEPS_PER_STG; j++)
        begin
            r = rem_step(r, s.dvd[DVD_PAD_W-1-j], frame_width_reg);
        end
        s.rem         = r;
        stage_next[0] = s;

        // Stages 1..DIV_STAGES-1: four remainder digits each
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            s = stage_reg[i-1];
            r = s.rem;
            for (int j = 0; j < STEPS_PER_STG; j++)
            begin
                r = rem_step(r, s.dvd[DVD_PAD_W-1-i*STEPS_PER_STG-j], frame_width_reg);
            end
            s.rem         = r;
            stage_next[i] = s;
        end

        // Band compares against k*width, bar window test
        s = stage_reg[DIV_STAGES-1];
        for (int k = 0; k < BAND_LAST; k++)
        begin
            s.band_therm[k] = CMP_W'({s.col, {BAND_LOG{1'b0}}}) >= CMP_W'(mult_reg[k]);
        end
        s.bar_on = (POS_W'(s.col) >= POS_W'(s.rem)) &&
                   (POS_W'(s.col) < POS_W'(s.rem) + POS_W'(BAR_WIDTH));
        stage_next[DIV_STAGES] = s;

        // Color select
        s    = stage_reg[DIV_STAGES];
        band = '0;
        for (int k = 0; k < BAND_LAST; k++)
        begin
            band = band + BAND_W'(s.band_therm[k]);
        end
        v = CHAN_ZERO;
        s.blue  = CHAN_ZERO;
        s.green = CHAN_ZERO;
        s.red   = CHAN_ZERO;
        if (s.in_frame)
        begin
            case (pattern_reg)
                PAT_MAGENTA:
                begin
                    s.blue = CHAN_MAX;
                    s.red  = CHAN_MAX;
                end
                PAT_GRID:
                begin
                    v       = s.grid ? CHAN_MAX : CHAN_ZERO;
                    s.blue  = v;
                    s.green = v;
                    s.red   = v;
                end
                PAT_GRAY:
                begin
                    v       = LEVEL_TABLE[band];
                    s.blue  = v;
                    s.green = v;
                    s.red   = v;
                end
                PAT_BAR:
                begin
                    v       = s.bar_on ? CHAN_MAX : CHAN_ZERO;
                    s.blue  = v;
                    s.green = v;
                    s.red   = v;
                end
                default:
                begin
                    s.blue = CHAN_ZERO;
                end
            endcase
        end
        stage_next[NUM_STAGES-1] = s;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BAND_LAST; k++)
        begin
            mult_reg[k] <= mult_next[k];
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (stage_ready[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign blue      = stage_reg[NUM_STAGES-1].blue;
    assign green     = stage_reg[NUM_STAGES-1].green;
    assign red       = stage_reg[NUM_STAGES-1].red;
    assign alpha     = CHAN_MAX;

endmodule

[hw/rtl/vtpg_checker.sv]
// Port-level checks for the video test pattern generator, bound to the top.
// Depends on vtpg_pkg and video_test_pattern_generator.
module vtpg_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [vtpg_pkg::CHAN_W-1:0] blue,
    input logic [vtpg_pkg::CHAN_W-1:0] green,
    input logic [vtpg_pkg::CHAN_W-1:0] red,
    input logic [vtpg_pkg::CHAN_W-1:0] alpha
);
    import vtpg_pkg::*;

    // Every pixel is opaque
    a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha == CHAN_MAX)
        else $error("alpha not opaque");

    // All patterns are gray or magenta, so blue and red always agree
    a_blue_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blue == red)
        else $error("blue and red differ");

    // Only magenta separates green from blue
    a_magenta_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && green != blue |-> green == CHAN_ZERO && blue == CHAN_MAX)
        else $error("color outside pattern set");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({blue, green, red}))
        else $error("stalled word changed");

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .alpha     (alpha)
);
